>>> hw/rtl/pva_pkg.sv
`default_nettype none
package pva_pkg;

    localparam int NUM_VOICES  = 16;
    localparam int VOICE_IDX_W = $clog2(NUM_VOICES);

    localparam logic [6:0]  NOTE_CENTER = 7'd60;
    // (2^17 + 1) / 3, exact floor of x/3 for any x below 2^17
    localparam logic [15:0] RECIP_3     = 16'd43691;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_ASSIGNED = 3'd1,
        ACT_STOLEN   = 3'd2,
        ACT_RELEASED = 3'd3,
        ACT_CLEARED  = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        CMD_ON,
        CMD_OFF,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] chan;
        logic [6:0] note;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/pva_front.sv
`default_nettype none
module pva_front
    import pva_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] operation,
    input  wire logic [3:0] midi_channel,
    input  wire logic [6:0] note_number,
    input  wire logic [6:0] velocity,
    output logic            busy,
    output cmd_t            cmd,
    output logic            cmd_valid,
    input  wire logic       cmd_pop
);

    cmd_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    cmd_t       new_cmd;

    // classify the transaction; a note on without velocity is a note off
    always_comb
    begin
        new_cmd.chan = midi_channel;
        new_cmd.note = note_number;
        unique case (op_t'(operation))
            OP_NOTE_ON:  new_cmd.kind = (velocity != 7'd0) ? CMD_ON : CMD_OFF;
            OP_NOTE_OFF: new_cmd.kind = CMD_OFF;
            OP_CLEAR:    new_cmd.kind = CMD_CLEAR;
            default:     new_cmd.kind = CMD_NOP;
        endcase
    end

    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd       = q_mem[rd_ptr_reg];
    assign cmd_valid = (count_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, cmd_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/pva_back.sv
`default_nettype none
module pva_back
    import pva_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cmd_t         cmd,
    input  wire logic         cmd_valid,
    output logic              cmd_pop,
    output logic              strobe,
    output logic [2:0]        action,
    output logic [3:0]        voice_index,
    output logic [6:0]        voice_note,
    output logic signed [15:0] pitch_volts,
    output logic              gate_on
);

    localparam logic [VOICE_IDX_W-1:0] LAST_VOICE = VOICE_IDX_W'(NUM_VOICES - 1);

    back_state_t state_reg, state_next;

    logic                   vbusy_reg [NUM_VOICES];
    logic [6:0]             vnote_reg [NUM_VOICES];
    logic [3:0]             vchan_reg [NUM_VOICES];
    logic [VOICE_IDX_W-1:0] ptr_reg;

    cmd_t                   cmd_reg;
    logic [VOICE_IDX_W-1:0] idx_reg;
    logic                   free_found_reg;
    logic [VOICE_IDX_W-1:0] free_idx_reg;
    logic [VOICE_IDX_W-1:0] target_reg;
    act_t                   act_reg;
    logic                   gate_reg;
    logic                   with_pitch_reg;
    logic [31:0]            prod_reg;
    logic                   neg_reg;

    logic                   strobe_reg;
    logic [2:0]             action_reg;
    logic [3:0]             voice_index_reg;
    logic [6:0]             voice_note_reg;
    logic signed [15:0]     pitch_volts_reg;
    logic                   gate_on_reg;

    // control from the state machine
    logic                   take_cmd;
    logic                   clear_all;
    logic                   scan_step;
    logic                   decide;
    logic                   load_out;
    logic                   write_on;
    logic                   write_off;
    logic                   steal;
    logic [VOICE_IDX_W-1:0] target_next;
    act_t                   act_next;
    logic                   gate_next;
    logic                   with_pitch_next;
    logic [2:0]             out_action_next;
    logic [3:0]             out_index_next;
    logic [6:0]             out_note_next;
    logic signed [15:0]     out_pitch_next;
    logic                   out_gate_next;

    // datapath helpers
    logic                   hit;
    logic                   cur_free;
    logic signed [7:0]      n_off;
    logic [6:0]             n_mag;
    logic [16:0]            x_val;
    logic [31:0]            prod_next;
    logic [14:0]            q_mag;

    assign hit = vbusy_reg[idx_reg] && (vnote_reg[idx_reg] == cmd_reg.note)
                 && (vchan_reg[idx_reg] == cmd_reg.chan);
    assign cur_free = !vbusy_reg[idx_reg];

    // |(note-60)*1024| + 1, then divide by 3 through the reciprocal
    assign n_off     = $signed({1'b0, cmd_reg.note}) - $signed({1'b0, NOTE_CENTER});
    assign n_mag     = n_off[7] ? 7'(-n_off) : n_off[6:0];
    assign x_val     = {n_mag, 10'd1};
    assign prod_next = 32'(x_val) * 32'(RECIP_3);
    assign q_mag     = prod_reg[31:17];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_pop         = 1'b0;
        take_cmd        = 1'b0;
        clear_all       = 1'b0;
        scan_step       = 1'b0;
        decide          = 1'b0;
        load_out        = 1'b0;
        write_on        = 1'b0;
        write_off       = 1'b0;
        steal           = 1'b0;
        target_next     = idx_reg;
        act_next        = ACT_NONE;
        gate_next       = 1'b0;
        with_pitch_next = 1'b0;
        out_action_next = ACT_NONE;
        out_index_next  = 4'd0;
        out_note_next   = 7'd0;
        out_pitch_next  = 16'sd0;
        out_gate_next   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind) inside
                        CMD_ON, CMD_OFF:
                        begin
                            take_cmd   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            clear_all       = 1'b1;
                            load_out        = 1'b1;
                            out_action_next = ACT_CLEARED;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit || (idx_reg == LAST_VOICE))
                begin
                    decide     = 1'b1;
                    state_next = ST_MUL;
                    if (cmd_reg.kind == CMD_ON)
                    begin
                        write_on        = 1'b1;
                        gate_next       = 1'b1;
                        with_pitch_next = 1'b1;
                        act_next        = ACT_ASSIGNED;
                        if (hit)
                        begin
                            target_next = idx_reg;
                        end
                        else if (free_found_reg)
                        begin
                            target_next = free_idx_reg;
                        end
                        else if (cur_free)
                        begin
                            target_next = idx_reg;
                        end
                        else
                        begin
                            steal       = 1'b1;
                            target_next = ptr_reg;
                            act_next    = ACT_STOLEN;
                        end
                    end
                    else if (hit)
                    begin
                        write_off       = 1'b1;
                        target_next     = idx_reg;
                        with_pitch_next = 1'b1;
                        act_next        = ACT_RELEASED;
                    end
                end
                else
                begin
                    scan_step = 1'b1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                load_out        = 1'b1;
                state_next      = ST_IDLE;
                out_action_next = act_reg;
                out_gate_next   = gate_reg;
                if (with_pitch_reg)
                begin
                    out_index_next = 4'(target_reg);
                    out_note_next  = cmd_reg.note;
                    out_pitch_next = neg_reg ? -$signed({1'b0, q_mag})
                                             : $signed({1'b0, q_mag});
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            cmd_reg <= cmd;
        end
        if (take_cmd)
        begin
            idx_reg <= '0;
        end
        else if (scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (scan_step && cur_free && !free_found_reg)
        begin
            free_idx_reg <= idx_reg;
        end
        if (decide)
        begin
            target_reg     <= target_next;
            act_reg        <= act_next;
            gate_reg       <= gate_next;
            with_pitch_reg <= with_pitch_next;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
            neg_reg  <= n_off[7];
        end
        if (load_out)
        begin
            action_reg      <= out_action_next;
            voice_index_reg <= out_index_next;
            voice_note_reg  <= out_note_next;
            pitch_volts_reg <= out_pitch_next;
            gate_on_reg     <= out_gate_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            ptr_reg        <= '0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                vbusy_reg[i] <= 1'b0;
                vnote_reg[i] <= NOTE_CENTER;
                vchan_reg[i] <= 4'd0;
            end
        end
        else
        begin
            strobe_reg <= load_out;
            if (take_cmd)
            begin
                free_found_reg <= 1'b0;
            end
            else if (scan_step && cur_free)
            begin
                free_found_reg <= 1'b1;
            end
            if (steal)
            begin
                ptr_reg <= (ptr_reg == LAST_VOICE) ? '0 : ptr_reg + 1'b1;
            end
            if (clear_all)
            begin
                for (int i = 0; i < NUM_VOICES; i++)
                begin
                    vbusy_reg[i] <= 1'b0;
                end
            end
            if (write_on)
            begin
                vbusy_reg[target_next] <= 1'b1;
                vnote_reg[target_next] <= cmd_reg.note;
                vchan_reg[target_next] <= cmd_reg.chan;
            end
            if (write_off)
            begin
                vbusy_reg[target_next] <= 1'b0;
            end
        end
    end

    assign strobe      = strobe_reg;
    assign action      = action_reg;
    assign voice_index = voice_index_reg;
    assign voice_note  = voice_note_reg;
    assign pitch_volts = pitch_volts_reg;
    assign gate_on     = gate_on_reg;

endmodule
`default_nettype wire

>>> hw/rtl/polyphonic_voice_allocator.sv
`default_nettype none
// Voice allocator for 16 voices driven by note events.
// Input channel: a transaction (operation, midi_channel, note_number,
// velocity) is taken at a rising edge where start is high and busy is low.
// A front stage classifies it into a two-entry command queue; busy is high
// only while that queue is full.
// Output channel: each transaction yields exactly one result (action,
// voice_index, voice_note, pitch_volts, gate_on), valid for the single cycle
// in which strobe is high. The receiver cannot stall; results are never held.
// Sequence: the front queue registers each transaction and the back end takes
// it from there. Clear all and unknown codes load their result directly. Note
// on and note off scan the voice table one voice per cycle, stopping at the
// first matching voice or the last voice, then pass the multiply state for the pitch.
// The queue takes new transactions while an earlier one is still in the back end.
// Reset: all voices free with note 60 and channel 0, steal pointer zero,
// queue empty, strobe low. No clearing pass is needed.
module polyphonic_voice_allocator
    import pva_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    operation,
    input  wire logic [3:0]    midi_channel,
    input  wire logic [6:0]    note_number,
    input  wire logic [6:0]    velocity,
    output logic               strobe,
    output logic [2:0]         action,
    output logic [3:0]         voice_index,
    output logic [6:0]         voice_note,
    output logic signed [15:0] pitch_volts,
    output logic               gate_on
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    pva_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .midi_channel (midi_channel),
        .note_number  (note_number),
        .velocity     (velocity),
        .busy         (busy),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop)
    );

    pva_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .strobe      (strobe),
        .action      (action),
        .voice_index (voice_index),
        .voice_note  (voice_note),
        .pitch_volts (pitch_volts),
        .gate_on     (gate_on)
    );

endmodule
`default_nettype wire

>>> dv/voice_alloc_checker.sv
`timescale 1ns / 100ps
module voice_alloc_checker
    import pva_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         operation,
    input  wire logic [3:0]         midi_channel,
    input  wire logic [6:0]         note_number,
    input  wire logic [6:0]         velocity,
    input  wire logic               strobe,
    input  wire logic [2:0]         action,
    input  wire logic [3:0]         voice_index,
    input  wire logic [6:0]         voice_note,
    input  wire logic signed [15:0] pitch_volts,
    input  wire logic               gate_on,
    output int                      mismatch_count,
    output int                      outstanding
);

    typedef struct packed {
        logic [2:0]         act;
        logic [3:0]         idx;
        logic [6:0]         note;
        logic signed [15:0] pitch;
        logic               gate;
    } voice_event_t;

    logic       voice_held [NUM_VOICES];
    logic [6:0] voice_last [NUM_VOICES];
    logic [3:0] voice_chan [NUM_VOICES];
    int         rr_ptr;

    voice_event_t expected_events[$];

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // Round (note-60)*1024/3 to nearest, symmetric about zero.
    function automatic logic signed [15:0] volts_of(input logic [6:0] nt);
        int scaled;
        scaled = (int'(nt) - int'(NOTE_CENTER)) * 1024;
        if (scaled >= 0)
            return 16'((scaled + 1) / 3);
        return -16'((1 - scaled) / 3);
    endfunction

    function automatic voice_event_t predict_allocation(input logic [1:0] op,
                                                        input logic [3:0] ch,
                                                        input logic [6:0] nt,
                                                        input logic [6:0] vel);
        voice_event_t r;
        int           hit;
        r   = '0;
        hit = -1;
        if (op == OP_NOTE_ON && vel == 7'd0)
            op = OP_NOTE_OFF;
        case (op)
            OP_NOTE_ON:
            begin
                r.act = ACT_ASSIGNED;
                for (int i = 0; i < NUM_VOICES; i++)
                    if (hit < 0 && voice_held[i] && voice_last[i] == nt && voice_chan[i] == ch)
                        hit = i;
                for (int i = 0; i < NUM_VOICES; i++)
                    if (hit < 0 && !voice_held[i])
                        hit = i;
                // steal only when every voice is taken
                if (hit < 0)
                begin
                    hit    = rr_ptr;
                    rr_ptr = (rr_ptr + 1) % NUM_VOICES;
                    r.act  = ACT_STOLEN;
                end
                voice_held[hit] = 1'b1;
                voice_last[hit] = nt;
                voice_chan[hit] = ch;
                r.idx   = 4'(hit);
                r.note  = nt;
                r.pitch = volts_of(nt);
                r.gate  = 1'b1;
            end
            OP_NOTE_OFF:
            begin
                r.act = ACT_NONE;
                for (int i = 0; i < NUM_VOICES; i++)
                    if (hit < 0 && voice_held[i] && voice_last[i] == nt && voice_chan[i] == ch)
                        hit = i;
                if (hit >= 0)
                begin
                    voice_held[hit] = 1'b0;
                    r.act   = ACT_RELEASED;
                    r.idx   = 4'(hit);
                    r.note  = voice_last[hit];
                    r.pitch = volts_of(voice_last[hit]);
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_VOICES; i++)
                    voice_held[i] = 1'b0;
                r.act = ACT_CLEARED;
            end
            default: r.act = ACT_NONE;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input voice_event_t want,
                          input voice_event_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t %s: exp act=%0d idx=%0d note=%0d pitch=%0d gate=%0d",
                      " | got act=%0d idx=%0d note=%0d pitch=%0d gate=%0d"},
                     $realtime, what, want.act, want.idx, want.note, want.pitch,
                     want.gate, got.act, got.idx, got.note, got.pitch, got.gate);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        voice_event_t got;
        voice_event_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                voice_held[i] = 1'b0;
                voice_last[i] = NOTE_CENTER;
                voice_chan[i] = 4'd0;
            end
            rr_ptr = 0;
            expected_events.delete();
        end
        else
        begin
            // check results before taking a new transaction
            if (strobe)
            begin
                got = '{action, voice_index, voice_note, pitch_volts, gate_on};
                if (expected_events.size() == 0)
                    report("result with nothing pending", '0, got);
                else
                begin
                    want = expected_events.pop_front();
                    if (got !== want)
                        report("result mismatch", want, got);
                end
            end
            if (start && !busy)
                expected_events.insert(expected_events.size(),
                                       predict_allocation(operation, midi_channel,
                                                          note_number, velocity));
        end
        outstanding = expected_events.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
module tb;
    import pva_pkg::*;

    localparam int RANDOM_EVENTS = 1100;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [1:0]         operation    = OP_NOTE_ON;
    logic [3:0]         midi_channel = 4'd0;
    logic [6:0]         note_number  = 7'd0;
    logic [6:0]         velocity     = 7'd0;
    logic               busy;
    logic               strobe;
    logic [2:0]         action;
    logic [3:0]         voice_index;
    logic [6:0]         voice_note;
    logic signed [15:0] pitch_volts;
    logic               gate_on;

    int         mismatch_count;
    int         outstanding;
    int         cycle_count = 0;
    bit         no_gaps     = 1'b0;
    logic [10:0] sounding_notes[$];

    polyphonic_voice_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .midi_channel (midi_channel),
        .note_number  (note_number),
        .velocity     (velocity),
        .strobe       (strobe),
        .action       (action),
        .voice_index  (voice_index),
        .voice_note   (voice_note),
        .pitch_volts  (pitch_volts),
        .gate_on      (gate_on)
    );

    voice_alloc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .midi_channel   (midi_channel),
        .note_number    (note_number),
        .velocity       (velocity),
        .strobe         (strobe),
        .action         (action),
        .voice_index    (voice_index),
        .voice_note     (voice_note),
        .pitch_volts    (pitch_volts),
        .gate_on        (gate_on),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Hold the transaction until the edge that accepts it; start stays high.
    task automatic send_event(input logic [1:0] op, input logic [3:0] ch,
                              input logic [6:0] nt, input logic [6:0] vel);
        start        <= 1'b1;
        operation    <= op;
        midi_channel <= ch;
        note_number  <= nt;
        velocity     <= vel;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (op == OP_NOTE_ON && vel != 7'd0)
        begin
            sounding_notes.insert(sounding_notes.size(), {ch, nt});
            if (sounding_notes.size() > 24)
                void'(sounding_notes.pop_front());
        end
        else if (op == OP_CLEAR)
            sounding_notes.delete();
    endtask

    task automatic idle_sender();
        int r;
        int n;
        r = $urandom_range(99);
        if (no_gaps || r < 60)
            n = 0;
        else if (r < 93)
            n = $urandom_range(3, 1);
        else
            n = $urandom_range(40, 8);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Mostly a small note and channel pool so reuse, release and steal all occur.
    task automatic pick_event(output logic [1:0] op, output logic [3:0] ch,
                              output logic [6:0] nt, output logic [6:0] vel);
        int r;
        r   = $urandom_range(99);
        ch  = 4'($urandom_range(3));
        nt  = 7'($urandom_range(66, 54));
        vel = 7'($urandom_range(127, 1));
        if (r < 12 || r >= 90)
        begin
            ch  = 4'($urandom_range(15));
            nt  = 7'($urandom_range(127));
            vel = 7'($urandom_range(127));
        end
        if (r < 50)
            op = OP_NOTE_ON;
        else if (r < 85)
        begin
            op = OP_NOTE_OFF;
            if (sounding_notes.size() != 0 && $urandom_range(3) != 0)
                {ch, nt} = sounding_notes[$urandom_range(sounding_notes.size() - 1)];
            if ($urandom_range(4) == 0)
            begin
                op  = OP_NOTE_ON;
                vel = 7'd0;
            end
        end
        else if (r < 88)
            op = OP_CLEAR;
        else if (r < 90)
            op = OP_RESERVED;
        else
            op = 2'($urandom_range(3));
    endtask

    initial
    begin : stimulus
        logic [1:0] op;
        logic [3:0] ch;
        logic [6:0] nt;
        logic [6:0] vel;
        int         issued;

        @(posedge rst_n);
        @(posedge clk);

        send_event(OP_NOTE_ON, 4'd0, 7'd0, 7'd127);
        idle_sender();
        send_event(OP_NOTE_ON, 4'd15, 7'd127, 7'd1);
        idle_sender();
        // same note and channel again: reuse the voice
        send_event(OP_NOTE_ON, 4'd15, 7'd127, 7'd64);
        idle_sender();
        send_event(OP_NOTE_OFF, 4'd15, 7'd127, 7'd0);
        idle_sender();
        send_event(OP_NOTE_OFF, 4'd3, 7'd50, 7'd127);
        idle_sender();
        // zero velocity releases like a note off
        send_event(OP_NOTE_ON, 4'd0, 7'd0, 7'd0);
        idle_sender();
        send_event(OP_RESERVED, 4'd15, 7'd127, 7'd127);
        idle_sender();
        send_event(OP_CLEAR, 4'd0, 7'd0, 7'd0);
        idle_sender();
        // fill every voice, then one more to force a steal
        for (int i = 0; i <= NUM_VOICES; i++)
        begin
            send_event(OP_NOTE_ON, 4'd9, 7'(30 + i), 7'd100);
            idle_sender();
        end
        wait_until_drained();

        issued = 0;
        while (issued < RANDOM_EVENTS)
        begin
            if (issued % 64 == 0)
                no_gaps = ($urandom_range(3) == 0);
            if (issued == RANDOM_EVENTS / 2)
                wait_until_drained();
            pick_event(op, ch, nt, vel);
            send_event(op, ch, nt, vel);
            if (op != OP_RESERVED)
                issued++;
            idle_sender();
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
